// ----- design/acs_pkg.sv -----
`timescale 1ns / 1ps

package acs_pkg;

  localparam int HALF_BITS = 14;

  typedef enum logic [2:0] {
    SIDE_NONE   = 3'd0,
    SIDE_INSIDE = 3'd1,
    SIDE_TOP    = 3'd2,
    SIDE_BOTTOM = 3'd3,
    SIDE_LEFT   = 3'd4,
    SIDE_RIGHT  = 3'd5
  } side_t;

endpackage

// ----- design/acs_slope_cmp.sv -----
`timescale 1ns / 1ps

module acs_slope_cmp #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [COORD_BITS-1:0]          vx,
  input  logic signed [COORD_BITS-1:0]          vy,
  input  logic signed [((COORD_BITS > acs_pkg::HALF_BITS) ? COORD_BITS :
                        acs_pkg::HALF_BITS + 1) + 1:0] dx,
  input  logic signed [((COORD_BITS > acs_pkg::HALF_BITS) ? COORD_BITS :
                        acs_pkg::HALF_BITS + 1) + 1:0] dy,
  output logic                                  lt
);
  import acs_pkg::*;

  localparam int EW = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS + 1) + 1;
  localparam int DW = EW + 1;
  localparam int PW = COORD_BITS + DW;

  localparam logic [1:0] RANK_NEG  = 2'd0;
  localparam logic [1:0] RANK_ZERO = 2'd1;
  localparam logic [1:0] RANK_POS  = 2'd2;

  logic                  vy_neg_c;
  logic                  dy_neg_c;
  logic [1:0]            ra_c;
  logic [1:0]            rc_c;

  logic [COORD_BITS-1:0] mvx;
  logic [COORD_BITS-1:0] mvy;
  logic [DW-1:0]         mdx;
  logic [DW-1:0]         mdy;
  logic [1:0]            ra3;
  logic [1:0]            rc3;
  logic                  vy_zero3;
  logic                  vx_neg3;

  logic [PW-1:0]         m1;
  logic [PW-1:0]         m2;
  logic [1:0]            ra4;
  logic [1:0]            rc4;
  logic                  vy_zero4;
  logic                  vx_neg4;

  always_comb begin
    vy_neg_c = vy[COORD_BITS-1];
    dy_neg_c = dy[DW-1];
    if (vx == '0) begin
      ra_c = RANK_ZERO;
    end else if (vx[COORD_BITS-1] ^ vy_neg_c) begin
      ra_c = RANK_NEG;
    end else begin
      ra_c = RANK_POS;
    end
    if (dx == '0) begin
      rc_c = RANK_ZERO;
    end else if (dx[DW-1] ^ dy_neg_c) begin
      rc_c = RANK_NEG;
    end else begin
      rc_c = RANK_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mvx      <= vx[COORD_BITS-1] ? $unsigned(-vx) : $unsigned(vx);
      mvy      <= vy_neg_c ? $unsigned(-vy) : $unsigned(vy);
      mdx      <= dx[DW-1] ? $unsigned(-dx) : $unsigned(dx);
      mdy      <= dy_neg_c ? $unsigned(-dy) : $unsigned(dy);
      ra3      <= ra_c;
      rc3      <= rc_c;
      vy_zero3 <= (vy == '0);
      vx_neg3  <= vx[COORD_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1       <= PW'(mvx) * PW'(mdy);
      m2       <= PW'(mdx) * PW'(mvy);
      ra4      <= ra3;
      rc4      <= rc3;
      vy_zero4 <= vy_zero3;
      vx_neg4  <= vx_neg3;
    end
  end

  always_comb begin
    if (vy_zero4) begin
      lt = vx_neg4;
    end else if (ra4 != rc4) begin
      lt = (ra4 < rc4);
    end else if (ra4 == RANK_ZERO) begin
      lt = 1'b0;
    end else if (ra4 == RANK_POS) begin
      lt = (m1 < m2);
    end else begin
      lt = (m1 > m2);
    end
  end

endmodule

// ----- design/aabb_collision_side_top.sv -----
`timescale 1ns / 1ps

// Classifies which side of box A box B strikes, using a nine-region test around A and, in a
// corner region, an exact cross-multiplied comparison of B's velocity slope with the corner
// offset slope. The block is fully pipelined: it accepts one box pair every cycle, unless the
// output is stalled, and the rate is held by the pair of multipliers in the fourth stage, each
// used once per word. A stall on the output freezes the whole pipeline, so no word is lost or
// repeated.

module aabb_collision_side_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        a_center_x,
  input  logic signed [COORD_BITS-1:0]        a_center_y,
  input  logic        [acs_pkg::HALF_BITS-1:0] a_half_width,
  input  logic        [acs_pkg::HALF_BITS-1:0] a_half_height,
  input  logic signed [COORD_BITS-1:0]        b_center_x,
  input  logic signed [COORD_BITS-1:0]        b_center_y,
  input  logic        [acs_pkg::HALF_BITS-1:0] b_half_width,
  input  logic        [acs_pkg::HALF_BITS-1:0] b_half_height,
  input  logic signed [COORD_BITS-1:0]        b_velocity_x,
  input  logic signed [COORD_BITS-1:0]        b_velocity_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output acs_pkg::side_t                      side
);
  import acs_pkg::*;

  localparam int EW = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS + 1) + 1;
  localparam int DW = EW + 1;
  localparam int ZW = EW - HALF_BITS;

  logic en;
  logic v1, v2, v3, v4;

  logic signed [EW-1:0] al, ar, at, ab, bl, br, bt, bb, bx1, by1;
  logic signed [COORD_BITS-1:0] vx1, vy1;

  logic                 inside_c, top_c, bot_c, right_c, left_c;
  logic                 tr_c, tl_c, bl_c, brc_c;
  logic                 corner_c;
  side_t                base_c, true_c;
  logic signed [DW-1:0] dx_c, dy_c;
  logic signed [DW-1:0] dx_ar, dx_al, dy_at, dy_ab;

  logic                 corner2, corner3, corner4;
  side_t                base2, base3, base4;
  side_t                true2, true3, true4;
  logic signed [DW-1:0] dx2, dy2;
  logic signed [COORD_BITS-1:0] vx2, vy2;
  logic                 lt;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      al  <= EW'(a_center_x) - signed'({{ZW{1'b0}}, a_half_width});
      ar  <= EW'(a_center_x) + signed'({{ZW{1'b0}}, a_half_width});
      at  <= EW'(a_center_y) + signed'({{ZW{1'b0}}, a_half_height});
      ab  <= EW'(a_center_y) - signed'({{ZW{1'b0}}, a_half_height});
      bl  <= EW'(b_center_x) - signed'({{ZW{1'b0}}, b_half_width});
      br  <= EW'(b_center_x) + signed'({{ZW{1'b0}}, b_half_width});
      bt  <= EW'(b_center_y) + signed'({{ZW{1'b0}}, b_half_height});
      bb  <= EW'(b_center_y) - signed'({{ZW{1'b0}}, b_half_height});
      bx1 <= EW'(b_center_x);
      by1 <= EW'(b_center_y);
      vx1 <= b_velocity_x;
      vy1 <= b_velocity_y;
    end
  end

  always_comb begin
    dx_ar    = DW'(bx1) - DW'(ar);
    dx_al    = DW'(bx1) - DW'(al);
    dy_at    = DW'(by1) - DW'(at);
    dy_ab    = DW'(by1) - DW'(ab);
    inside_c = (al < bx1) && (bx1 < ar) && (ab < by1) && (by1 < at);
    top_c    = (at < by1) && (al <= bx1) && (bx1 <= ar);
    bot_c    = (by1 < ab) && (al <= bx1) && (bx1 <= ar);
    right_c  = (ar < bx1) && (ab <= by1) && (by1 <= at);
    left_c   = (bx1 < al) && (ab <= by1) && (by1 <= at);
    tr_c     = (ar < bx1) && (at < by1);
    tl_c     = (bx1 < al) && (at < by1);
    bl_c     = (bx1 < al) && (by1 < ab);
    brc_c    = (ar < bx1) && (by1 < ab);
    corner_c = 1'b0;
    base_c   = SIDE_NONE;
    true_c   = SIDE_NONE;
    dx_c     = dx_ar;
    dy_c     = dy_at;
    priority if (inside_c) begin
      base_c = SIDE_INSIDE;
    end else if (top_c) begin
      base_c = (bb <= at) ? SIDE_TOP : SIDE_NONE;
    end else if (bot_c) begin
      base_c = (ab <= bt) ? SIDE_BOTTOM : SIDE_NONE;
    end else if (right_c) begin
      base_c = (bl <= ar) ? SIDE_RIGHT : SIDE_NONE;
    end else if (left_c) begin
      base_c = (al <= br) ? SIDE_LEFT : SIDE_NONE;
    end else if (tr_c) begin
      corner_c = (bl < ar) && (bb < at);
      base_c   = corner_c ? SIDE_TOP : SIDE_NONE;
      true_c   = SIDE_RIGHT;
      dx_c     = dx_ar;
      dy_c     = dy_at;
    end else if (tl_c) begin
      corner_c = (al < br) && (at < bb);
      base_c   = corner_c ? SIDE_LEFT : SIDE_NONE;
      true_c   = SIDE_TOP;
      dx_c     = dx_al;
      dy_c     = dy_at;
    end else if (bl_c) begin
      corner_c = (al < br) && (ab < bt);
      base_c   = corner_c ? SIDE_BOTTOM : SIDE_NONE;
      true_c   = SIDE_LEFT;
      dx_c     = dx_al;
      dy_c     = dy_ab;
    end else if (brc_c) begin
      corner_c = (bl < ar) && (ab < bt);
      base_c   = corner_c ? SIDE_RIGHT : SIDE_NONE;
      true_c   = SIDE_BOTTOM;
      dx_c     = dx_ar;
      dy_c     = dy_ab;
    end else begin
      base_c = SIDE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      corner2 <= corner_c;
      base2   <= base_c;
      true2   <= true_c;
      dx2     <= dx_c;
      dy2     <= dy_c;
      vx2     <= vx1;
      vy2     <= vy1;
      corner3 <= corner2;
      base3   <= base2;
      true3   <= true2;
      corner4 <= corner3;
      base4   <= base3;
      true4   <= true3;
      side    <= (corner4 && lt) ? true4 : base4;
    end
  end

  acs_slope_cmp #(
    .COORD_BITS(COORD_BITS)
  ) u_slope (
    .clk(clk),
    .en (en),
    .vx (vx2),
    .vy (vy2),
    .dx (dx2),
    .dy (dy2),
    .lt (lt)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import acs_pkg::*;

  localparam int COORD_W = 16;
  localparam int RANDOM_WORDS = 1300;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic [HALF_BITS-1:0] aw;
    logic [HALF_BITS-1:0] ah;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic [HALF_BITS-1:0] bw;
    logic [HALF_BITS-1:0] bh;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
  } box_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] a_center_x = '0;
  logic signed [COORD_W-1:0] a_center_y = '0;
  logic [HALF_BITS-1:0] a_half_width = '0;
  logic [HALF_BITS-1:0] a_half_height = '0;
  logic signed [COORD_W-1:0] b_center_x = '0;
  logic signed [COORD_W-1:0] b_center_y = '0;
  logic [HALF_BITS-1:0] b_half_width = '0;
  logic [HALF_BITS-1:0] b_half_height = '0;
  logic signed [COORD_W-1:0] b_velocity_x = '0;
  logic signed [COORD_W-1:0] b_velocity_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  side_t side;

  box_pair_t pending_pairs[$];
  side_t expected_sides[$];
  int total_words;
  int accepted_words = 0;
  int mismatches = 0;
  int cycle_count = 0;

  aabb_collision_side_top #(.COORD_BITS(COORD_W)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .a_center_x(a_center_x),
    .a_center_y(a_center_y),
    .a_half_width(a_half_width),
    .a_half_height(a_half_height),
    .b_center_x(b_center_x),
    .b_center_y(b_center_y),
    .b_half_width(b_half_width),
    .b_half_height(b_half_height),
    .b_velocity_x(b_velocity_x),
    .b_velocity_y(b_velocity_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .side(side)
  );

  always #2 clk = ~clk;

  function automatic bit velocity_below(longint vx, longint vy, longint dx, longint dy);
    if (vy == 0) begin
      return vx < 0;
    end
    if (vy < 0) begin
      vx = -vx;
      vy = -vy;
    end
    if (dy < 0) begin
      dx = -dx;
      dy = -dy;
    end
    return vx * dy < dx * vy;
  endfunction

  function automatic side_t predict_side(box_pair_t p);
    longint ax, ay, bx, by, vx, vy;
    longint al, ar, at, ab, bl, br, bt, bb;
    ax = p.ax;
    ay = p.ay;
    bx = p.bx;
    by = p.by;
    vx = p.vx;
    vy = p.vy;
    al = ax - longint'(p.aw);
    ar = ax + longint'(p.aw);
    at = ay + longint'(p.ah);
    ab = ay - longint'(p.ah);
    bl = bx - longint'(p.bw);
    br = bx + longint'(p.bw);
    bt = by + longint'(p.bh);
    bb = by - longint'(p.bh);
    if (al < bx && bx < ar && ab < by && by < at) begin
      return SIDE_INSIDE;
    end
    if (at < by && al <= bx && bx <= ar) begin
      return (bb <= at) ? SIDE_TOP : SIDE_NONE;
    end
    if (by < ab && al <= bx && bx <= ar) begin
      return (ab <= bt) ? SIDE_BOTTOM : SIDE_NONE;
    end
    if (ar < bx && ab <= by && by <= at) begin
      return (bl <= ar) ? SIDE_RIGHT : SIDE_NONE;
    end
    if (bx < al && ab <= by && by <= at) begin
      return (al <= br) ? SIDE_LEFT : SIDE_NONE;
    end
    if (ar < bx && at < by) begin
      if (bl < ar && bb < at) begin
        return velocity_below(vx, vy, bx - ar, by - at) ? SIDE_RIGHT : SIDE_TOP;
      end
      return SIDE_NONE;
    end
    if (bx < al && at < by) begin
      if (al < br && at < bb) begin
        return velocity_below(vx, vy, bx - al, by - at) ? SIDE_TOP : SIDE_LEFT;
      end
      return SIDE_NONE;
    end
    if (bx < al && by < ab) begin
      if (al < br && ab < bt) begin
        return velocity_below(vx, vy, bx - al, by - ab) ? SIDE_LEFT : SIDE_BOTTOM;
      end
      return SIDE_NONE;
    end
    if (ar < bx && by < ab) begin
      if (bl < ar && ab < bt) begin
        return velocity_below(vx, vy, bx - ar, by - ab) ? SIDE_BOTTOM : SIDE_RIGHT;
      end
      return SIDE_NONE;
    end
    return SIDE_NONE;
  endfunction

  function automatic box_pair_t make_pair(longint ax, longint ay, longint aw, longint ah,
                                          longint bx, longint by, longint bw, longint bh,
                                          longint vx, longint vy);
    box_pair_t p;
    p.ax = ax[COORD_W-1:0];
    p.ay = ay[COORD_W-1:0];
    p.aw = aw[HALF_BITS-1:0];
    p.ah = ah[HALF_BITS-1:0];
    p.bx = bx[COORD_W-1:0];
    p.by = by[COORD_W-1:0];
    p.bw = bw[HALF_BITS-1:0];
    p.bh = bh[HALF_BITS-1:0];
    p.vx = vx[COORD_W-1:0];
    p.vy = vy[COORD_W-1:0];
    return p;
  endfunction

  function automatic longint random_half();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 600);
  endfunction

  // Offset of B's center from A's center along one axis, often right on an edge.
  function automatic longint center_offset(longint a_ext, longint b_ext);
    longint span;
    span = a_ext + b_ext + 64;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? a_ext : -a_ext;
      1: return $urandom_range(0, 1) ? a_ext + b_ext : -(a_ext + b_ext);
      2: return 0;
      default: return longint'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic box_pair_t random_pair();
    longint ax, ay, aw, ah, bw, bh, vx, vy;
    if ($urandom_range(0, 4) == 0) begin
      return make_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    ax = longint'($urandom_range(0, 65535)) - 32768;
    ay = longint'($urandom_range(0, 65535)) - 32768;
    aw = random_half();
    ah = random_half();
    bw = random_half();
    bh = random_half();
    vx = longint'($urandom_range(0, 65535)) - 32768;
    vy = longint'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 9))
      0: vy = 0;
      1: vx = 0;
      2: begin
        vx = 0;
        vy = 0;
      end
      3: begin
        vx = longint'($urandom_range(0, 40)) - 20;
        vy = longint'($urandom_range(0, 40)) - 20;
      end
      default: ;
    endcase
    return make_pair(ax, ay, aw, ah, ax + center_offset(aw, bw), ay + center_offset(ah, bh),
                     bw, bh, vx, vy);
  endfunction

  initial begin
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 10, 10, 5, 5, 3, -4));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 0, 150, 50, 50, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 0, 300, 50, 50, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 0, -150, 60, 60, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 150, 0, 60, 60, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, -150, 0, 60, 60, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 100, 50, 10, 10, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 150, 150, 60, 60, 10, 20));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 150, 150, 60, 60, 30, 10));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 150, 150, 60, 60, 7, 7));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 150, 150, 60, 60, -5, 0));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 150, 150, 60, 60, 5, 0));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 150, 150, 60, 60, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 150, 150, 60, 60, 0, 5));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 150, 150, 60, 60, -10, -20));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, -150, 150, 60, 60, -10, 20));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, -150, 150, 60, 60, 30, -10));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, -150, -150, 60, 60, 10, 20));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, -150, -150, 60, 60, -30, 10));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 150, -150, 60, 60, 10, -20));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 150, -150, 60, 60, 30, 10));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 300, 300, 10, 10, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(-32768, -32768, 16383, 16383, 32767, 32767, 16383, 16383,
                                      -32768, -32768));
    pending_pairs.push_back(make_pair(32767, 32767, 16383, 16383, -32768, -32768, 16383, 16383,
                                      32767, 32767));
    pending_pairs.push_back(make_pair(32767, -32768, 16383, 0, 32767, -32768, 0, 16383,
                                      -32768, 32767));
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pending_pairs.push_back(random_pair());
    end
    total_words = pending_pairs.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (accepted_words < total_words) @(posedge clk);
    while (expected_sides.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_sides.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    box_pair_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        p.ax = a_center_x;
        p.ay = a_center_y;
        p.aw = a_half_width;
        p.ah = a_half_height;
        p.bx = b_center_x;
        p.by = b_center_y;
        p.bw = b_half_width;
        p.bh = b_half_height;
        p.vx = b_velocity_x;
        p.vy = b_velocity_y;
        expected_sides.push_back(predict_side(p));
        accepted_words++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          p = pending_pairs.pop_front();
          a_center_x <= p.ax;
          a_center_y <= p.ay;
          a_half_width <= p.aw;
          a_half_height <= p.ah;
          b_center_x <= p.bx;
          b_center_y <= p.by;
          b_half_width <= p.bw;
          b_half_height <= p.bh;
          b_velocity_x <= p.vx;
          b_velocity_y <= p.vy;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches among stall patterns every so often.
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(64, 256);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= (cycle_count % 5 < 2);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk) begin
    side_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sides.size() == 0) begin
        $error("side: unexpected word, actual %0d", side);
        mismatches++;
      end else begin
        want = expected_sides.pop_front();
        if (side !== want) begin
          $error("side mismatch: expected %0d, actual %0d", want, side);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
